// ===== hw/rtl/mppr_pkg.sv =====
// Median prediction plane rebuild: shared types, widths and codes.
// No dependencies; imported by mppr_ctrl, mppr_predict and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mppr_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int LINE_W    = 13;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 8;
    localparam int CNT_W     = (LINE_W > ADDR_W + 1) ? LINE_W : ADDR_W + 1;
    localparam int GRAD_W    = PIX_W + 2;

    localparam logic [LINE_W-1:0] LINE_WIDTH_RST = LINE_W'(640);
    localparam logic [MODE_W-1:0] PLANE_MODE_RST = '0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_MODE = 1'b1;

    // plane modes
    localparam logic [MODE_W-1:0] MODE_RGB    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_YUV420 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LUMA   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CHROMA = 2'd3;

    // row phases
    localparam logic [1:0] PHASE_ROW0  = 2'd0;
    localparam logic [1:0] PHASE_ROW1  = 2'd1;
    localparam logic [1:0] PHASE_LATER = 2'd2;

    // left-predicted head length of row 1
    localparam int HEAD_LUMA  = 4;
    localparam int HEAD_OTHER = 2;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [ADDR_W-1:0] col_t;

    typedef struct packed {
        pixel_t             residual;
        logic               start;
        col_t               col;
        logic [1:0]         phase;
        logic               last;
        logic [MODE_W-1:0]  mode;
    } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mppr_line_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the previous row of the plane.
`timescale 1ns / 1ps
`default_nettype none

module mppr_line_ram #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0]         wr_data,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [DATA_W-1:0]         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mppr_ctrl.sv =====
// Configuration registers, column counter and row phase tracking.
// Depends on mppr_pkg; produces the control word of each accepted transaction.
`timescale 1ns / 1ps
`default_nettype none

module mppr_ctrl (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mppr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mppr_pkg::LINE_W-1:0]     cfg_wdata,
    input  wire logic                            accept,
    input  wire logic [mppr_pkg::PIX_W-1:0]      s_residual,
    input  wire logic                            s_plane_start,
    output mppr_pkg::item_t                      item
);
    import mppr_pkg::*;

    logic [LINE_W-1:0] line_width_reg, line_width_next;
    logic [MODE_W-1:0] plane_mode_reg, plane_mode_next;
    col_t              col_reg, col_next;
    logic [1:0]        phase_reg, phase_next;

    col_t              col_cur;
    logic [1:0]        phase_cur;
    logic [CNT_W-1:0]  lw_ext, w_eff;
    logic              last;

    always_comb begin
        line_width_next = line_width_reg;
        plane_mode_next = plane_mode_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LINE_WIDTH: line_width_next = cfg_wdata;
                REG_PLANE_MODE: plane_mode_next = cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        col_cur   = s_plane_start ? '0 : col_reg;
        phase_cur = s_plane_start ? PHASE_ROW0 : phase_reg;
        lw_ext    = CNT_W'(line_width_reg);
        if (lw_ext == '0) begin
            w_eff = CNT_W'(1);
        end else if (lw_ext > CNT_W'(MAX_WIDTH)) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = lw_ext;
        end
        last = (CNT_W'(col_cur) + CNT_W'(1)) >= w_eff;

        col_next   = col_reg;
        phase_next = phase_reg;
        if (accept) begin
            col_next   = last ? '0 : col_cur + ADDR_W'(1);
            phase_next = (last && phase_cur != PHASE_LATER) ? phase_cur + 2'd1 : phase_cur;
        end

        item.residual = s_residual;
        item.start    = s_plane_start;
        item.col      = col_cur;
        item.phase    = phase_cur;
        item.last     = last;
        item.mode     = plane_mode_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RST;
            plane_mode_reg <= PLANE_MODE_RST;
            col_reg        <= '0;
            phase_reg      <= PHASE_ROW0;
        end else begin
            line_width_reg <= line_width_next;
            plane_mode_reg <= plane_mode_next;
            col_reg        <= col_next;
            phase_reg      <= phase_next;
        end
    end

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PHASE_ROW0 || phase_reg == PHASE_ROW1 || phase_reg == PHASE_LATER)
        else $error("row phase out of range");

    a_start_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_plane_start && !last |=> col_reg == ADDR_W'(1))
        else $error("plane start did not restart column count");

endmodule

`default_nettype wire

// ===== hw/rtl/mppr_predict.sv =====
// Prediction stage: takes the row memory read data, forms the left or median
// prediction, writes the pixel back and holds the result register.
// Depends on mppr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mppr_predict (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire mppr_pkg::item_t               item,
    input  wire logic [mppr_pkg::PIX_W-1:0]    rd_data,
    output logic                               wr_en,
    output logic [mppr_pkg::ADDR_W-1:0]        wr_addr,
    output logic [mppr_pkg::PIX_W-1:0]         wr_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mppr_pkg::PIX_W-1:0]         m_pixel,
    output logic                               m_row_end
);
    import mppr_pkg::*;

    logic   b_vld_reg, b_vld_next;
    item_t  b_item_reg;
    logic   b_fwd_reg;
    pixel_t fwd_data_reg;
    pixel_t left_reg, left_next;
    pixel_t tl_reg, tl_next;
    logic   m_vld_reg, m_vld_next;
    pixel_t m_pixel_reg;
    logic   m_end_reg;

    logic   accept, b_fire, fwd_hit;
    pixel_t top, left_cur, tl_cur, tl_sel, pix;
    logic   in_head, wide_grad;
    logic signed [GRAD_W-1:0] a_s, b_s, g_s, lo_s, hi_s, m_s, pred_s;

    assign b_fire   = b_vld_reg && (!m_vld_reg || m_ready);
    assign in_ready = !b_vld_reg || b_fire;
    assign accept   = in_valid && in_ready;
    assign fwd_hit  = b_fire && (b_item_reg.col == item.col);

    always_comb begin
        top       = b_fwd_reg ? fwd_data_reg : rd_data;
        left_cur  = b_item_reg.start ? '0 : left_reg;
        tl_cur    = b_item_reg.start ? '0 : tl_reg;
        in_head   = (b_item_reg.mode == MODE_LUMA) ? (b_item_reg.col < ADDR_W'(HEAD_LUMA))
                                                   : (b_item_reg.col < ADDR_W'(HEAD_OTHER));
        wide_grad = (b_item_reg.mode == MODE_RGB) || (b_item_reg.mode == MODE_YUV420);

        if (b_item_reg.phase == PHASE_ROW1 && b_item_reg.col == '0) begin
            tl_sel = (b_item_reg.mode == MODE_YUV420) ? top : left_cur;
        end else begin
            tl_sel = tl_cur;
        end

        a_s = $signed({2'b00, left_cur});
        b_s = $signed({2'b00, top});
        g_s = a_s + b_s - $signed({2'b00, tl_sel});
        if (!wide_grad) begin
            g_s = $signed({2'b00, g_s[PIX_W-1:0]});
        end
        lo_s   = (a_s < b_s) ? a_s : b_s;
        hi_s   = (a_s < b_s) ? b_s : a_s;
        m_s    = (hi_s < g_s) ? hi_s : g_s;
        pred_s = (lo_s > m_s) ? lo_s : m_s;

        pix       = left_cur + b_item_reg.residual;
        left_next = left_reg;
        tl_next   = tl_reg;
        if (b_item_reg.phase == PHASE_ROW0) begin
            tl_next = tl_cur;
            if (b_item_reg.mode == MODE_LUMA && b_item_reg.col == '0) begin
                pix       = b_item_reg.residual;
                left_next = '0;
            end else begin
                left_next = pix;
            end
        end else if (b_item_reg.phase == PHASE_ROW1 && !wide_grad && in_head) begin
            left_next = pix;
            tl_next   = top;
        end else begin
            pix       = pred_s[PIX_W-1:0] + b_item_reg.residual;
            left_next = pix;
            tl_next   = top;
        end
        if (b_item_reg.last) begin
            left_next = pix;
        end
        if (!b_fire) begin
            left_next = left_reg;
            tl_next   = tl_reg;
        end

        b_vld_next = accept ? 1'b1 : (b_fire ? 1'b0 : b_vld_reg);
        m_vld_next = b_fire ? 1'b1 : (m_ready ? 1'b0 : m_vld_reg);
    end

    assign wr_en     = b_fire;
    assign wr_addr   = b_item_reg.col;
    assign wr_data   = pix;
    assign m_valid   = m_vld_reg;
    assign m_pixel   = m_pixel_reg;
    assign m_row_end = m_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            left_reg  <= '0;
            tl_reg    <= '0;
        end else begin
            b_vld_reg <= b_vld_next;
            m_vld_reg <= m_vld_next;
            left_reg  <= left_next;
            tl_reg    <= tl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_item_reg   <= item;
            b_fwd_reg    <= fwd_hit;
            fwd_data_reg <= pix;
        end
        if (b_fire) begin
            m_pixel_reg <= pix;
            m_end_reg   <= b_item_reg.last;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && b_vld_reg |-> b_fire)
        else $error("prediction stage overwritten");

    a_fire_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        b_fire |=> m_vld_reg)
        else $error("result lost after prediction");

    a_forward_set: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && fwd_hit |=> b_fwd_reg && b_vld_reg)
        else $error("same-column write not forwarded");

endmodule

`default_nettype wire

// ===== hw/rtl/median_prediction_plane_rebuild.sv =====
// Top level of the median prediction plane rebuild block.
// Depends on mppr_pkg, mppr_ctrl, mppr_predict and mppr_line_ram.
//
// One residual byte in and one pixel out per transaction, one transaction per
// clock sustained while m_ready is high. The previous-row read data and the
// output are registered. Pixel values flow through the row memory in place; a
// write and a read of the same column in the same cycle are forwarded. Row
// memory entries are undefined until first written, so there is no clearing
// pass after reset. Configuration takes effect for the next transaction, and
// the user writes it only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module median_prediction_plane_rebuild (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mppr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mppr_pkg::LINE_W-1:0]     cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [mppr_pkg::PIX_W-1:0]      s_residual,
    input  wire logic                            s_plane_start,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [mppr_pkg::PIX_W-1:0]           m_pixel,
    output logic                                 m_row_end
);
    import mppr_pkg::*;

    item_t  item;
    logic   accept;
    pixel_t rd_data;
    logic   wr_en;
    col_t   wr_addr;
    pixel_t wr_data;

    assign accept = s_valid && s_ready;

    mppr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .accept        (accept),
        .s_residual    (s_residual),
        .s_plane_start (s_plane_start),
        .item          (item)
    );

    mppr_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIX_W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (item.col),
        .rd_data (rd_data)
    );

    mppr_predict u_predict (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .item      (item),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pixel   (m_pixel),
        .m_row_end (m_row_end)
    );

endmodule

`default_nettype wire
